/* hdl/clipped_line_rasterizer_core_defines.svh */
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion, clocked on clk_i.
`ifndef CLIPPED_LINE_RASTERIZER_CORE_DEFINES_SVH
`define CLIPPED_LINE_RASTERIZER_CORE_DEFINES_SVH
// implication checked at every clock edge outside reset
`define CLR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define CLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/clr_pkg.sv */
// Package for the clipped line rasterizer: types, constants, color conversion.
// No dependencies.
package clr_pkg;
  localparam int unsigned CoordBits    = 12;
  localparam int unsigned SlopeFracDef = 16;
  localparam int unsigned ClipPasses   = 8;
  localparam int unsigned AddrBits     = 4;
  localparam int unsigned QueueDepth   = 2;

  localparam logic        OP_LOAD = 1'b0;
  localparam logic        OP_STEP = 1'b1;

  localparam logic [1:0]  ST_ACCEPT = 2'd0;
  localparam logic [1:0]  ST_REJECT = 2'd1;
  localparam logic [1:0]  ST_IDLE   = 2'd2;

  localparam logic [1:0]  FMT_555 = 2'd0;
  localparam logic [1:0]  FMT_565 = 2'd1;
  localparam logic [1:0]  FMT_24  = 2'd2;
  localparam logic [1:0]  FMT_32  = 2'd3;

  localparam logic [AddrBits-1:0] REG_WIDTH  = 4'h0;
  localparam logic [AddrBits-1:0] REG_HEIGHT = 4'h4;
  localparam logic [AddrBits-1:0] REG_FORMAT = 4'h8;

  typedef struct packed {
    logic        opcode;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic [31:0] line_color;
  } in_item_t;

  typedef struct packed {
    logic        is_pixel;
    logic [1:0]  status;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] pixel_color;
    logic        line_done;
    logic        last;
  } out_item_t;

  // screen settings seen by the front end
  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [1:0]  fmt;
  } cfg_t;

  typedef enum logic [2:0] {
    FS_IDLE, FS_DIV, FS_CLIP, FS_SETUP, FS_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BS_IDLE, BS_EMIT
  } back_state_e;

  function automatic logic [31:0] convert_color(input logic [31:0] c, input logic [1:0] f);
    logic [31:0] r;
    begin
      case (f)
        FMT_555: r = ((c >> 3) & 32'h001F) | ((c >> 6) & 32'h03E0) | ((c >> 9) & 32'h7C00);
        FMT_565: r = ((c >> 3) & 32'h001F) | ((c >> 5) & 32'h07E0) | ((c >> 8) & 32'hF800);
        FMT_24:  r = c & 32'h00FF_FFFF;
        default: r = c;
      endcase
      return r;
    end
  endfunction
endpackage

/* hdl/clr_if.sv */
// Valid/ready channel carrying one payload word.
// Depends on nothing; payload type is a parameter.
interface clr_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/clipped_line_rasterizer_core.sv */
// Line engine: a load that needs clipping runs up to two serial slope divisions, each of
// 18+SLOPE_FRACTION_BITS quotient bits, then one clip pass at a time, eight at most; other
// loads go through FS_DIV and FS_SETUP to FS_PUSH. A step goes from FS_IDLE to FS_PUSH,
// and its first word leaves from the back end's BS_EMIT; the back end then stays busy until
// every result word is taken. Coordinates are 12 bits; screen sizes above 4096 act as 4096.
// The front end clips, the back end walks; a one-entry command hand-off parts them.
module clipped_line_rasterizer_core #(
  parameter int unsigned SLOPE_FRACTION_BITS = clr_pkg::SlopeFracDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  clr_if.sink                            in_ch,
  clr_if.source                          out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [clr_pkg::AddrBits-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import clr_pkg::*;
  cfg_t cfg_q, cfg_d;
  logic cv, cr, cl, crj;
  logic signed [14:0] x1, y1, x2, y2;
  logic [31:0] col;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (paddr)
        REG_WIDTH:  cfg_d.width  = pwdata[12:0];
        REG_HEIGHT: cfg_d.height = pwdata[12:0];
        REG_FORMAT: cfg_d.fmt    = pwdata[1:0];
        default: ;
      endcase
    end
    unique case (paddr)
      REG_WIDTH:  prdata = {19'd0, cfg_q.width};
      REG_HEIGHT: prdata = {19'd0, cfg_q.height};
      REG_FORMAT: prdata = {30'd0, cfg_q.fmt};
      default:    prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= '{width: 13'd640, height: 13'd480, fmt: FMT_32};
    else cfg_q <= cfg_d;
  end

  clr_front #(.SlopeFrac(SLOPE_FRACTION_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_ch,
    .cmd_valid_o(cv), .cmd_ready_i(cr), .cmd_load_o(cl), .cmd_reject_o(crj),
    .cmd_x1_o(x1), .cmd_y1_o(y1), .cmd_x2_o(x2), .cmd_y2_o(y2), .cmd_color_o(col)
  );

  clr_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cv), .cmd_ready_o(cr), .cmd_load_i(cl),
    .cmd_reject_i(crj), .cmd_x1_i(x1), .cmd_y1_i(y1), .cmd_x2_i(x2), .cmd_y2_i(y2),
    .cmd_color_i(col), .out_ch
  );
endmodule

/* hdl/clr_div.sv */
// Restoring serial divider, one quotient bit a cycle, truncates toward zero.
// Depends on nothing.
module clr_div #(
  parameter int unsigned NumBits = 40,
  parameter int unsigned DenBits = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [NumBits-1:0] num_i,
  input  logic signed [DenBits-1:0] den_i,
  output logic                      busy_o,
  output logic signed [NumBits-1:0] quo_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);
  logic [NumBits-1:0] quo_q, quo_d;
  logic [DenBits-1:0] rem_q, rem_d, den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic [DenBits:0]   trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q; neg_d = neg_q;
    trial = '0;
    if (start_i) begin
      quo_d = num_i[NumBits-1] ? NumBits'(-num_i) : NumBits'(num_i);
      den_d = den_i[DenBits-1] ? DenBits'(-den_i) : DenBits'(den_i);
      neg_d = num_i[NumBits-1] ^ den_i[DenBits-1];
      rem_d = '0;
      cnt_d = CntBits'(NumBits);
    end else if (cnt_q != '0) begin
      trial = {rem_q, quo_q[NumBits-1]} - {1'b0, den_q};
      if (!trial[DenBits]) begin
        rem_d = trial[DenBits-1:0];
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DenBits-2:0], quo_q[NumBits-1]};
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

/* hdl/clr_front.sv */
// Front end: accepts items, clips loads and passes each command to the back end.
// Depends on clr_pkg and clr_div.
module clr_front #(
  parameter int unsigned SlopeFrac = clr_pkg::SlopeFracDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clr_pkg::cfg_t        cfg_i,
  clr_if.sink                  in_ch,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output logic                 cmd_load_o,
  output logic                 cmd_reject_o,
  output logic signed [14:0]   cmd_x1_o,
  output logic signed [14:0]   cmd_y1_o,
  output logic signed [14:0]   cmd_x2_o,
  output logic signed [14:0]   cmd_y2_o,
  output logic [31:0]          cmd_color_o
);
  import clr_pkg::*;
  localparam int unsigned NB = 18 + SlopeFrac;   // scaled numerator width
  localparam int unsigned PB = 27 + NB;          // product width
  localparam logic signed [27:0] Lim = 28'sd1 << 24;

  front_state_e st_q, st_d;
  logic signed [27:0] x1_q, y1_q, x2_q, y2_q, x1_d, y1_d, x2_d, y2_d;
  logic signed [NB-1:0] ydx_q, xdy_q, ydx_d, xdy_d;
  logic [1:0] dv_q, dv_d;
  logic [3:0] pass_q, pass_d;
  logic [13:0] w_q, h_q, w_d, h_d;
  logic [31:0] col_q, col_d;
  logic op_q, op_d, rej_q, rej_d;

  logic div_start, div_busy;
  logic signed [NB-1:0] div_num, div_quo;
  logic signed [16:0] div_den;

  clr_div #(.NumBits(NB), .DenBits(17)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  function automatic logic [3:0] oc(input logic signed [27:0] x, y,
                                    input logic [13:0] w, h);
    logic [3:0] m;
    begin
      m = '0;
      if (x < 0) m[0] = 1'b1; else if (x >= $signed({14'd0, w})) m[1] = 1'b1;
      if (y < 0) m[2] = 1'b1; else if (y >= $signed({14'd0, h})) m[3] = 1'b1;
      return m;
    end
  endfunction

  function automatic logic signed [27:0] sat(input logic signed [PB-1:0] v);
    begin
      if (v > PB'(Lim)) return Lim;
      if (v < -PB'(Lim)) return -Lim;
      return v[27:0];
    end
  endfunction

  logic [3:0] m1, m2, m;
  logic signed [PB-1:0] prod, adj, off;
  logic signed [27:0] nx, ny;
  logic [13:0] lim_w, lim_h;

  always_comb begin
    lim_w = (cfg_i.width > 13'd0 && {1'b0, cfg_i.width} > (14'd1 << CoordBits))
            ? (14'd1 << CoordBits) : {1'b0, cfg_i.width};
    lim_h = ({1'b0, cfg_i.height} > (14'd1 << CoordBits))
            ? (14'd1 << CoordBits) : {1'b0, cfg_i.height};
    m1 = oc(x1_q, y1_q, w_q, h_q);
    m2 = oc(x2_q, y2_q, w_q, h_q);
    m  = (m1 != '0) ? m1 : m2;
    // one clip move per cycle: a single multiply, then truncating shift
    off = '0; prod = '0; nx = '0; ny = '0;
    if (m[2] || m[3]) begin
      off  = m[2] ? PB'(y1_q) : PB'(y1_q) + 1 - PB'($signed({14'd0, h_q}));
      prod = off * PB'(xdy_q);
    end else begin
      off  = m[0] ? PB'(x1_q) : PB'(x1_q) + 1 - PB'($signed({14'd0, w_q}));
      prod = off * PB'(ydx_q);
    end
    adj = (prod < 0) ? prod + PB'((1 << SlopeFrac) - 1) : prod;
    adj = adj >>> SlopeFrac;
    if (m[2] || m[3]) begin
      ny = m[2] ? 28'sd0 : 28'($signed({14'd0, h_q}) - 1);
      nx = sat(PB'(x1_q) - adj);
    end else begin
      nx = m[0] ? 28'sd0 : 28'($signed({14'd0, w_q}) - 1);
      ny = sat(PB'(y1_q) - adj);
    end
  end

  always_comb begin
    st_d = st_q;
    x1_d = x1_q; y1_d = y1_q; x2_d = x2_q; y2_d = y2_q;
    ydx_d = ydx_q; xdy_d = xdy_q; dv_d = dv_q; pass_d = pass_q;
    w_d = w_q; h_d = h_q; col_d = col_q; op_d = op_q; rej_d = rej_q;
    div_start = 1'b0; div_num = '0; div_den = '0;
    unique case (st_q)
      FS_IDLE: begin
        if (in_ch.valid) begin
          op_d  = in_ch.data.opcode;
          x1_d  = 28'(signed'(in_ch.data.start_x)); y1_d = 28'(signed'(in_ch.data.start_y));
          x2_d  = 28'(signed'(in_ch.data.end_x));   y2_d = 28'(signed'(in_ch.data.end_y));
          col_d = convert_color(in_ch.data.line_color, cfg_i.fmt);
          w_d = lim_w; h_d = lim_h; rej_d = 1'b0;
          ydx_d = '0; xdy_d = '0; dv_d = 2'd0; pass_d = '0;
          st_d = (in_ch.data.opcode == OP_STEP) ? FS_PUSH : FS_DIV;
        end
      end
      FS_DIV: begin
        if ((m1 | m2) == '0) st_d = FS_SETUP;
        else if (!div_busy) begin
          if (dv_q == 2'd0) begin
            dv_d = 2'd1;
            if (x1_q != x2_q) begin
              div_start = 1'b1;
              div_num = NB'(y2_q - y1_q) <<< SlopeFrac;
              div_den = 17'(x2_q - x1_q);
            end
          end else if (dv_q == 2'd1) begin
            if (x1_q != x2_q) ydx_d = div_quo;
            dv_d = 2'd2;
            if (y1_q != y2_q) begin
              div_start = 1'b1;
              div_num = NB'(x2_q - x1_q) <<< SlopeFrac;
              div_den = 17'(y2_q - y1_q);
            end
          end else begin
            if (y1_q != y2_q) xdy_d = div_quo;
            st_d = FS_CLIP;
          end
        end
      end
      FS_CLIP: begin
        if ((m1 | m2) == '0) st_d = FS_SETUP;
        else if ((m1 & m2) != '0 || pass_q == 4'(ClipPasses)) begin
          rej_d = 1'b1; st_d = FS_PUSH;
        end else begin
          if (m1 != '0) begin x1_d = nx; y1_d = ny; end
          else begin x2_d = nx; y2_d = ny; end
          pass_d = pass_q + 1'b1;
        end
      end
      FS_SETUP: st_d = FS_PUSH;
      FS_PUSH:  if (cmd_ready_i) st_d = FS_IDLE;
      default:  st_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= FS_IDLE;
    else st_q <= st_d;
  end
  always_ff @(posedge clk_i) begin
    x1_q <= x1_d; y1_q <= y1_d; x2_q <= x2_d; y2_q <= y2_d;
    ydx_q <= ydx_d; xdy_q <= xdy_d; dv_q <= dv_d; pass_q <= pass_d;
    w_q <= w_d; h_q <= h_d; col_q <= col_d; op_q <= op_d; rej_q <= rej_d;
  end

  assign in_ch.ready  = (st_q == FS_IDLE);
  assign cmd_valid_o  = (st_q == FS_PUSH);
  assign cmd_load_o   = (op_q == OP_LOAD);
  assign cmd_reject_o = rej_q;
  assign cmd_x1_o = x1_q[14:0]; assign cmd_y1_o = y1_q[14:0];
  assign cmd_x2_o = x2_q[14:0]; assign cmd_y2_o = y2_q[14:0];
  assign cmd_color_o = col_q;
endmodule

/* hdl/clr_back.sv */
// Back end: holds line state, runs the two-ended Bresenham walk, emits results.
// Depends on clr_pkg.
module clr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  logic               cmd_load_i,
  input  logic               cmd_reject_i,
  input  logic signed [14:0] cmd_x1_i,
  input  logic signed [14:0] cmd_y1_i,
  input  logic signed [14:0] cmd_x2_i,
  input  logic signed [14:0] cmd_y2_i,
  input  logic [31:0]        cmd_color_i,
  clr_if.source              out_ch
);
  import clr_pkg::*;
  back_state_e st_q, st_d;
  logic active_q, active_d, xmaj_q, xmaj_d;
  logic [11:0] steps_q, steps_d, nx_q, ny_q, fx_q, fy_q, nx_d, ny_d, fx_d, fy_d;
  logic signed [15:0] err_q, err_d;
  logic [13:0] tmaj_q, tmin_q, tmaj_d, tmin_d;
  logic signed [1:0] sx_q, sy_q, sx_d, sy_d;
  logic [31:0] col_q, col_d;
  out_item_t buf_q [3];
  out_item_t buf_d [3];
  logic [1:0] cnt_q, cnt_d, rd_q, rd_d;
  logic signed [15:0] dxs, dys;
  logic [14:0] adx, ady;
  logic [11:0] nnx, nny, nfx, nfy;
  logic signed [15:0] e2;
  logic meet;

  always_comb begin
    dxs = 16'(cmd_x2_i) - 16'(cmd_x1_i);
    dys = 16'(cmd_y2_i) - 16'(cmd_y1_i);
    adx = dxs[15] ? 15'(-dxs) : 15'(dxs);
    ady = dys[15] ? 15'(-dys) : 15'(dys);
    // one walk step
    nnx = nx_q; nny = ny_q; nfx = fx_q; nfy = fy_q; e2 = err_q;
    if (err_q > 0) begin
      e2 = err_q - 16'($signed({2'b0, tmaj_q}));
      if (xmaj_q) begin nny = ny_q + 12'(sy_q); nfy = fy_q - 12'(sy_q); end
      else begin nnx = nx_q + 12'(sx_q); nfx = fx_q - 12'(sx_q); end
    end
    e2 = e2 + 16'($signed({2'b0, tmin_q}));
    if (xmaj_q) begin nnx = nx_q + 12'(sx_q); nfx = fx_q - 12'(sx_q); end
    else begin nny = ny_q + 12'(sy_q); nfy = fy_q - 12'(sy_q); end
    meet = xmaj_q ? (nnx == nfx) : (nny == nfy);
  end

  function automatic out_item_t mk(input logic p, input logic [1:0] s, input logic [11:0] x,
                                   input logic [11:0] y, input logic [31:0] c,
                                   input logic d, input logic l);
    out_item_t o;
    begin
      o.is_pixel = p; o.status = s; o.pixel_x = x; o.pixel_y = y;
      o.pixel_color = c; o.line_done = d; o.last = l;
      return o;
    end
  endfunction

  always_comb begin
    st_d = st_q; active_d = active_q; xmaj_d = xmaj_q; steps_d = steps_q;
    nx_d = nx_q; ny_d = ny_q; fx_d = fx_q; fy_d = fy_q; err_d = err_q;
    tmaj_d = tmaj_q; tmin_d = tmin_q; sx_d = sx_q; sy_d = sy_q; col_d = col_q;
    buf_d = buf_q; cnt_d = cnt_q; rd_d = rd_q;
    unique case (st_q)
      BS_IDLE: begin
        if (cmd_valid_i) begin
          rd_d = '0; st_d = BS_EMIT;
          if (cmd_load_i) begin
            cnt_d = 2'd1;
            if (cmd_reject_i) begin
              active_d = 1'b0;
              buf_d[0] = mk(1'b0, ST_REJECT, '0, '0, '0, 1'b0, 1'b1);
            end else begin
              buf_d[0] = mk(1'b0, ST_ACCEPT, '0, '0, '0, 1'b0, 1'b1);
              active_d = 1'b1; col_d = cmd_color_i;
              sx_d = dxs[15] ? -2'sd1 : ((dxs != 0) ? 2'sd1 : 2'sd0);
              sy_d = dys[15] ? -2'sd1 : ((dys != 0) ? 2'sd1 : 2'sd0);
              nx_d = cmd_x1_i[11:0]; ny_d = cmd_y1_i[11:0];
              fx_d = cmd_x2_i[11:0]; fy_d = cmd_y2_i[11:0];
              xmaj_d = adx >= ady;
              if (adx >= ady) begin
                tmaj_d = 14'(adx << 1); tmin_d = 14'(ady << 1);
                err_d = 16'(ady << 1) - 16'(adx); steps_d = 12'((adx + 1) >> 1);
              end else begin
                tmaj_d = 14'(ady << 1); tmin_d = 14'(adx << 1);
                err_d = 16'(adx << 1) - 16'(ady); steps_d = 12'((ady + 1) >> 1);
              end
            end
          end else if (!active_q) begin
            cnt_d = 2'd1;
            buf_d[0] = mk(1'b0, ST_IDLE, '0, '0, '0, 1'b0, 1'b1);
          end else if (steps_q == '0) begin
            cnt_d = 2'd1; active_d = 1'b0;
            buf_d[0] = mk(1'b1, ST_ACCEPT, nx_q, ny_q, col_q, 1'b1, 1'b1);
          end else begin
            buf_d[0] = mk(1'b1, ST_ACCEPT, nx_q, ny_q, col_q, 1'b0, 1'b0);
            nx_d = nnx; ny_d = nny; fx_d = nfx; fy_d = nfy; err_d = e2;
            steps_d = steps_q - 1'b1;
            if (steps_q == 12'd1) begin
              active_d = 1'b0;
              if (meet) begin
                cnt_d = 2'd3;
                buf_d[1] = mk(1'b1, ST_ACCEPT, fx_q, fy_q, col_q, 1'b0, 1'b0);
                buf_d[2] = mk(1'b1, ST_ACCEPT, nnx, nny, col_q, 1'b1, 1'b1);
              end else begin
                cnt_d = 2'd2;
                buf_d[1] = mk(1'b1, ST_ACCEPT, fx_q, fy_q, col_q, 1'b1, 1'b1);
              end
            end else begin
              cnt_d = 2'd2;
              buf_d[1] = mk(1'b1, ST_ACCEPT, fx_q, fy_q, col_q, 1'b0, 1'b1);
            end
          end
        end
      end
      BS_EMIT: begin
        if (out_ch.ready) begin
          rd_d = rd_q + 1'b1;
          if (rd_q + 1'b1 == cnt_q) st_d = BS_IDLE;
        end
      end
      default: st_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BS_IDLE; active_q <= 1'b0; cnt_q <= '0; rd_q <= '0;
    end else begin
      st_q <= st_d; active_q <= active_d; cnt_q <= cnt_d; rd_q <= rd_d;
    end
  end
  always_ff @(posedge clk_i) begin
    xmaj_q <= xmaj_d; steps_q <= steps_d; nx_q <= nx_d; ny_q <= ny_d;
    fx_q <= fx_d; fy_q <= fy_d; err_q <= err_d; tmaj_q <= tmaj_d; tmin_q <= tmin_d;
    sx_q <= sx_d; sy_q <= sy_d; col_q <= col_d; buf_q <= buf_d;
  end

  assign cmd_ready_o  = (st_q == BS_IDLE);
  assign out_ch.valid = (st_q == BS_EMIT);
  assign out_ch.data  = buf_q[rd_q];
endmodule

/* hdl/clr_checker.sv */
// Port-level checks for the line engine, bound to the top level.
// Depends on clr_pkg and the assertion macros header.
`include "clipped_line_rasterizer_core_defines.svh"
module clr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid,
  input logic             out_ready,
  input clr_pkg::out_item_t out_data,
  input logic             pready
);
  import clr_pkg::*;
  `CLR_ASSERT_IMP(a_status_no_pixel, out_valid && !out_data.is_pixel, out_data.last)
  `CLR_ASSERT_IMP(a_pixel_status, out_valid && out_data.is_pixel, out_data.status == ST_ACCEPT)
  `CLR_ASSERT_IMP(a_done_last, out_valid && out_data.line_done, out_data.last)
  `CLR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `CLR_ASSERT_IMP(a_pready, 1'b1, pready)
endmodule

bind clipped_line_rasterizer_core clr_checker u_chk (
  .clk_i, .rst_ni, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data), .pready
);
